// ===== rtl/skin_weight_top4_normalize_core_macros.svh =====
// Assertion macros for the skin weight top-4 normalize RTL.
`ifndef SKIN_WEIGHT_TOP4_NORMALIZE_CORE_MACROS_SVH
`define SKIN_WEIGHT_TOP4_NORMALIZE_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every rising clock edge outside reset.
`define SWTN_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, checked on every rising clock edge outside reset.
`define SWTN_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SWTN_ASSERT_IMPLY(label, ante, cons, msg)
`define SWTN_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/swtn_pkg.sv =====
// Shared types, constants and codes for the skin weight top-4 normalize core.
package swtn_pkg;

   localparam int VERTICES_DEF = 4096;
   localparam int MAX_BONES    = 64;

   localparam int W_BITS  = 64;
   localparam int B_BITS  = 32;
   localparam int C_BITS  = 3;
   localparam int ENTRY_W = W_BITS + B_BITS + C_BITS;

   localparam logic [15:0] Q_ONE = 16'd32768;

   // Result status codes
   localparam logic [1:0] RESULT_ADDED       = 2'd0;
   localparam logic [1:0] RESULT_SKIPPED     = 2'd1;
   localparam logic [1:0] RESULT_UNSUPPORTED = 2'd2;
   localparam logic [1:0] RESULT_EMITTED     = 2'd3;

   // Request functions
   localparam logic FUNC_ADD  = 1'b0;
   localparam logic FUNC_EMIT = 1'b1;

   // Register indexes (paddr bit 2)
   localparam logic REG_VERTEX_COUNT = 1'b0;
   localparam logic REG_BONE_COUNT   = 1'b1;

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_READ   = 7'b0000100,
      ST_UPDATE = 7'b0001000,
      ST_PREP   = 7'b0010000,
      ST_DIVIDE = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   typedef struct packed {
      logic load;
      logic mem_read;
      logic write_add;
      logic emit_capture;
      logic div_load;
      logic div_step;
      logic clear_step;
   } cmd_type;

   typedef struct packed {
      logic early;
      logic func;
      logic clear_last;
      logic div_last;
   } sts_type;

endpackage

// ===== rtl/swtn_ctrl.sv =====
// Control state machine: sequences clear sweep, table access and division.
`include "skin_weight_top4_normalize_core_macros.svh"
module swtn_ctrl
   import swtn_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (sts.early) begin
               state_in = ST_DONE;
            end else begin
               cmd.mem_read = 1'b1;
               state_in     = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (sts.func == FUNC_ADD) begin
               cmd.write_add = 1'b1;
               state_in      = ST_DONE;
            end else begin
               cmd.emit_capture = 1'b1;
               state_in         = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.div_load = 1'b1;
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Advance state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   `SWTN_ASSERT_NEXT(a_load_reads, cmd.load, state_ff == ST_READ, "load not followed by read")
   `SWTN_ASSERT_IMPLY(a_rsp_blocks_req, rsp_valid, req_stall, "request taken while result waits")
   `SWTN_ASSERT_NEXT(a_div_ends, cmd.div_step && sts.div_last, state_ff == ST_DONE, "divide overrun")
   `SWTN_ASSERT_IMPLY(a_clear_excl, cmd.clear_step, !cmd.write_add && !cmd.emit_capture, "write during clear")

endmodule

// ===== rtl/swtn_dp.sv =====
// Datapath: vertex table, top-4 insertion and four-lane restoring divider.
module swtn_dp
   import swtn_pkg::*;
#(
   parameter int VERTICES = VERTICES_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic [12:0] vertex_count,
   input  logic [9:0]  bone_count,
   input  logic        req_func,
   input  logic [11:0] req_vertex_index,
   input  logic [7:0]  req_bone_index,
   input  logic [15:0] req_weight,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_weight0,
   output logic [15:0] rsp_weight1,
   output logic [15:0] rsp_weight2,
   output logic [15:0] rsp_weight3,
   output logic [31:0] rsp_packed_bones
);

   localparam int ADDR_W = $clog2(VERTICES);

   logic [ENTRY_W-1:0] mem [VERTICES];

   logic              func_ff;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [7:0]        bone_ff;
   logic [15:0]       wt_ff;
   logic [1:0]        status_ff, status_in;
   logic [ENTRY_W-1:0] rd_ff;
   logic [ADDR_W-1:0] clr_ptr_ff;
   logic [15:0]       mw_ff [4];
   logic [31:0]       packed_ff;
   logic [17:0]       sum_ff;
   logic              zero_sum_ff;
   logic [18:0]       rem_ff [4];
   logic [15:0]       quo_ff [4];
   logic [3:0]        cnt_ff;

   logic [ADDR_W+11:0] vi_ext;
   logic               in_range;
   logic               unsupported;

   // Classify the request at transfer
   always_comb begin
      vi_ext      = {{ADDR_W{1'b0}}, req_vertex_index};
      addr_in     = vi_ext[ADDR_W-1:0];
      unsupported = bone_count > 10'(MAX_BONES);
      in_range    = ({1'b0, req_vertex_index} < vertex_count) &&
                    ({20'd0, req_vertex_index} < 32'(VERTICES));
      if (unsupported) begin
         status_in = RESULT_UNSUPPORTED;
      end else if (!in_range) begin
         status_in = RESULT_SKIPPED;
      end else if (req_func == FUNC_EMIT) begin
         status_in = RESULT_EMITTED;
      end else begin
         status_in = RESULT_ADDED;
      end
   end

   // Unpack the entry read from the table
   logic [15:0] w [4];
   logic [7:0]  b [4];
   logic [2:0]  n, lim, pos, n_new;
   logic        found;
   logic [15:0] nw [4];
   logic [7:0]  nb [4];
   logic [ENTRY_W-1:0] new_entry;
   logic [15:0] mw [4];
   logic [31:0] mb;
   logic [17:0] sum;

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         w[j] = rd_ff[16*j +: 16];
         b[j] = rd_ff[W_BITS + 8*j +: 8];
      end
      n     = (rd_ff[ENTRY_W-1 -: C_BITS] > 3'd4) ? 3'd4 : rd_ff[ENTRY_W-1 -: C_BITS];
      lim   = (n < 3'd4) ? n : 3'd3;
      n_new = (n < 3'd4) ? n + 3'd1 : 3'd4;

      // Find the insert slot: after every weight that is greater or equal
      pos   = n;
      found = 1'b0;
      for (int j = 0; j < 4; j++) begin
         if (!found && (3'(j) < n) && (wt_ff > w[j])) begin
            pos   = 3'(j);
            found = 1'b1;
         end
      end

      // Shift lower-ranked slots down and drop in the new influence
      for (int j = 0; j < 4; j++) begin
         nw[j] = w[j];
         nb[j] = b[j];
      end
      for (int j = 1; j < 4; j++) begin
         if ((3'(j) > pos) && (3'(j) <= lim)) begin
            nw[j] = w[j-1];
            nb[j] = b[j-1];
         end
      end
      for (int j = 0; j < 4; j++) begin
         if (3'(j) == pos) begin
            nw[j] = wt_ff;
            nb[j] = bone_ff;
         end
      end
      new_entry = {n_new, nb[3], nb[2], nb[1], nb[0], nw[3], nw[2], nw[1], nw[0]};

      // Mask unused slots and form the sum for emit
      sum = '0;
      mb  = '0;
      for (int j = 0; j < 4; j++) begin
         mw[j]        = (3'(j) < n) ? w[j] : 16'd0;
         mb[8*j +: 8] = (3'(j) < n) ? b[j] : 8'd0;
         sum          = sum + {2'b00, mw[j]};
      end
   end

   // Table write port: clear sweep, add update or emit clear
   logic              we;
   logic [ADDR_W-1:0] wa;
   logic [ENTRY_W-1:0] wd;

   always_comb begin
      we = cmd.clear_step | (cmd.write_add & (pos < 3'd4)) | cmd.emit_capture;
      wa = cmd.clear_step ? clr_ptr_ff : addr_ff;
      wd = cmd.write_add ? new_entry : '0;
   end

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      if (cmd.mem_read) rd_ff <= mem[addr_ff];
   end

   // Clear sweep pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ptr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_ptr_ff <= clr_ptr_ff + 1'b1;
      end
   end

   // Hold the request
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff   <= req_func;
         addr_ff   <= addr_in;
         bone_ff   <= req_bone_index;
         wt_ff     <= req_weight;
         status_ff <= status_in;
      end
   end

   // Divider lanes: one quotient bit per lane each step
   logic [18:0] t [4];
   logic        ge [4];
   logic [31:0] num [4];

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         t[j]   = {rem_ff[j][17:0], quo_ff[j][15]};
         ge[j]  = t[j] >= {1'b0, sum_ff};
         num[j] = {1'b0, mw_ff[j], 15'd0} + {15'd0, sum_ff[17:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         packed_ff   <= '0;
         zero_sum_ff <= 1'b0;
         for (int j = 0; j < 4; j++) quo_ff[j] <= '0;
      end
      if (cmd.emit_capture) begin
         packed_ff   <= mb;
         sum_ff      <= sum;
         zero_sum_ff <= (sum == 18'd0);
         for (int j = 0; j < 4; j++) mw_ff[j] <= mw[j];
      end
      if (cmd.div_load) begin
         for (int j = 0; j < 4; j++) begin
            rem_ff[j] <= {3'b000, num[j][31:16]};
            quo_ff[j] <= num[j][15:0];
         end
      end
      if (cmd.div_step) begin
         for (int j = 0; j < 4; j++) begin
            rem_ff[j] <= ge[j] ? (t[j] - {1'b0, sum_ff}) : t[j];
            quo_ff[j] <= {quo_ff[j][14:0], ge[j]};
         end
      end
   end

   // Step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.div_load) begin
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff + 4'd1;
      end
   end

   // Status to controller
   always_comb begin
      sts.early      = (status_ff == RESULT_SKIPPED) || (status_ff == RESULT_UNSUPPORTED);
      sts.func       = func_ff;
      sts.clear_last = (clr_ptr_ff == ADDR_W'(VERTICES - 1));
      sts.div_last   = (cnt_ff == 4'd15);
   end

   // Result fields
   always_comb begin
      rsp_status       = status_ff;
      rsp_packed_bones = packed_ff;
      rsp_weight0      = zero_sum_ff ? Q_ONE : quo_ff[0];
      rsp_weight1      = zero_sum_ff ? 16'd0 : quo_ff[1];
      rsp_weight2      = zero_sum_ff ? 16'd0 : quo_ff[2];
      rsp_weight3      = zero_sum_ff ? 16'd0 : quo_ff[3];
   end

endmodule

// ===== rtl/skin_weight_top4_normalize_core.sv =====
// Top level: configuration registers, controller and datapath.
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_stall | func, vertex_index, bone_index, weight
//  rsp     | out       | rsp_valid / rsp_stall | status, weight0..3, packed_bones
//  csr     | in        | APB psel/penable      | vertex_count (0x0), bone_count (0x4)
//
// One item at a time. Add: table read, then insert and write back when the weight ranks.
// Emit: read, capture, divider load and the 16 steps of the four-lane restoring
// divider. Skipped or unsupported: the result follows with no table access.
// After the result transfer the block returns to idle before taking a request.
// After reset a clear sweep writes every table entry, one per cycle, with
// req_stall high. A stalled result holds the block busy.
module skin_weight_top4_normalize_core
   import swtn_pkg::*;
#(
   parameter int VERTICES = VERTICES_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [11:0] req_vertex_index,
   input  logic [7:0]  req_bone_index,
   input  logic [15:0] req_weight,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_weight0,
   output logic [15:0] rsp_weight1,
   output logic [15:0] rsp_weight2,
   output logic [15:0] rsp_weight3,
   output logic [31:0] rsp_packed_bones,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [12:0] vertex_count_ff;
   logic [9:0]  bone_count_ff;
   cmd_type     cmd;
   sts_type     sts;

   assign csr_pready = 1'b1;

   // Register write on the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= '0;
         bone_count_ff   <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr[2])
            REG_VERTEX_COUNT: vertex_count_ff <= csr_pwdata[12:0];
            REG_BONE_COUNT:   bone_count_ff   <= csr_pwdata[9:0];
            default:          vertex_count_ff <= vertex_count_ff;
         endcase
      end
   end

   // Register read
   always_comb begin
      case (csr_paddr[2])
         REG_VERTEX_COUNT: csr_prdata = {19'd0, vertex_count_ff};
         REG_BONE_COUNT:   csr_prdata = {22'd0, bone_count_ff};
         default:          csr_prdata = '0;
      endcase
   end

   swtn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   swtn_dp #(
      .VERTICES (VERTICES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .vertex_count     (vertex_count_ff),
      .bone_count       (bone_count_ff),
      .req_func         (req_func),
      .req_vertex_index (req_vertex_index),
      .req_bone_index   (req_bone_index),
      .req_weight       (req_weight),
      .rsp_status       (rsp_status),
      .rsp_weight0      (rsp_weight0),
      .rsp_weight1      (rsp_weight1),
      .rsp_weight2      (rsp_weight2),
      .rsp_weight3      (rsp_weight3),
      .rsp_packed_bones (rsp_packed_bones)
   );

endmodule

// ===== verif/tb.sv =====
// Testbench for the skin weight top-4 selection and normalization core.
`timescale 1ns / 100ps

module tb;
   import swtn_pkg::*;

   typedef struct {
      logic [1:0]  status;
      logic [15:0] w [4];
      logic [31:0] bones;
   } skin_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_func = FUNC_ADD;
   logic [11:0] req_vertex_index = '0;
   logic [7:0]  req_bone_index = '0;
   logic [15:0] req_weight = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_weight0, rsp_weight1, rsp_weight2, rsp_weight3;
   logic [31:0] rsp_packed_bones;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   skin_weight_top4_normalize_core u_dut (.*);

   always #1 clock = ~clock;

   // Predictor state: per-vertex top-4 table and register copies
   logic [15:0] tbl_w [VERTICES_DEF][4];
   logic [7:0]  tbl_b [VERTICES_DEF][4];
   int          tbl_n [VERTICES_DEF];
   logic [12:0] vertex_count_q = '0;
   logic [9:0]  bone_count_q = '0;

   skin_result_type expected_results [$];
   int  mismatches = 0;
   int  sender_idle_pct = 0;
   int  stall_pct = 0;
   int  quiet_cycles = 0;

   // Predict one item and update the table copy
   function automatic skin_result_type predict_influence(logic func, logic [11:0] vi,
                                                         logic [7:0] bone, logic [15:0] wt);
      skin_result_type r;
      int n, pos;
      logic [31:0] sum;
      r.status = RESULT_ADDED;
      r.bones = '0;
      for (int j = 0; j < 4; j++) r.w[j] = '0;
      if (bone_count_q > MAX_BONES) begin
         r.status = RESULT_UNSUPPORTED;
         return r;
      end
      if (vi >= vertex_count_q) begin
         r.status = RESULT_SKIPPED;
         return r;
      end
      n = tbl_n[vi];
      if (func == FUNC_ADD) begin
         pos = n;
         for (int j = n - 1; j >= 0; j--)
            if (wt > tbl_w[vi][j]) pos = j;
         if (pos < 4) begin
            for (int j = (n < 4) ? n : 3; j > pos; j--) begin
               tbl_w[vi][j] = tbl_w[vi][j-1];
               tbl_b[vi][j] = tbl_b[vi][j-1];
            end
            tbl_w[vi][pos] = wt;
            tbl_b[vi][pos] = bone;
            if (n < 4) tbl_n[vi] = n + 1;
         end
         return r;
      end
      r.status = RESULT_EMITTED;
      sum = '0;
      for (int j = 0; j < 4; j++) begin
         if (j < n) begin
            sum += tbl_w[vi][j];
            r.bones[8*j +: 8] = tbl_b[vi][j];
         end
      end
      if (sum != 0) begin
         for (int j = 0; j < 4; j++)
            if (j < n)
               r.w[j] = 16'((({32'd0, tbl_w[vi][j]} * 64'd32768) + sum / 2) / sum);
      end else
         r.w[0] = Q_ONE;
      for (int j = 0; j < 4; j++) begin
         tbl_w[vi][j] = '0;
         tbl_b[vi][j] = '0;
      end
      tbl_n[vi] = 0;
      return r;
   endfunction

   // Drive one transfer on the request channel; valid stays up until the next item
   task automatic send_influence(logic func, logic [11:0] vi, logic [7:0] bone,
                                 logic [15:0] wt);
      while (sender_idle_pct > 0 && $urandom_range(99, 0) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_vertex_index <= vi;
      req_bone_index <= bone;
      req_weight <= wt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_results.insert(expected_results.size(),
                              predict_influence(func, vi, bone, wt));
      @(negedge clock);
   endtask

   // Drop valid and hold until every expected result has come
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic write_reg(logic idx, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == REG_VERTEX_COUNT) vertex_count_q = value[12:0];
      else bone_count_q = value[9:0];
      @(negedge clock);
   endtask

   task automatic configure(logic [12:0] vcount, logic [9:0] bcount);
      wait_drained();
      write_reg(REG_VERTEX_COUNT, 32'(vcount));
      write_reg(REG_BONE_COUNT, 32'(bcount));
   endtask

   // Directed: field extremes, ties, overflow past four, zero sums, emits
   task automatic test_directed();
      configure(13'd4096, 10'd64);
      send_influence(FUNC_EMIT, 12'd0, 8'd0, 16'd0);
      send_influence(FUNC_ADD, 12'd4095, 8'd255, 16'hFFFF);
      send_influence(FUNC_ADD, 12'd4095, 8'd1, 16'd32768);
      send_influence(FUNC_ADD, 12'd4095, 8'd2, 16'd32768);
      send_influence(FUNC_ADD, 12'd4095, 8'd3, 16'd0);
      send_influence(FUNC_ADD, 12'd4095, 8'd4, 16'd100);
      send_influence(FUNC_ADD, 12'd4095, 8'd5, 16'd32768);
      send_influence(FUNC_EMIT, 12'd4095, 8'hAA, 16'h5555);
      send_influence(FUNC_ADD, 12'd7, 8'd9, 16'd0);
      send_influence(FUNC_ADD, 12'd7, 8'd10, 16'd0);
      send_influence(FUNC_EMIT, 12'd7, 8'd0, 16'd0);
      send_influence(FUNC_ADD, 12'd8, 8'd200, 16'd1);
      send_influence(FUNC_ADD, 12'd8, 8'd201, 16'd2);
      send_influence(FUNC_ADD, 12'd8, 8'd202, 16'd3);
      send_influence(FUNC_EMIT, 12'd8, 8'd0, 16'd0);
      send_influence(FUNC_ADD, 12'd9, 8'd1, 16'd1);
      send_influence(FUNC_EMIT, 12'd9, 8'd0, 16'd0);
      configure(13'd10, 10'd0);
      send_influence(FUNC_ADD, 12'd10, 8'd1, 16'd5);
      send_influence(FUNC_EMIT, 12'd4095, 8'd1, 16'd5);
      send_influence(FUNC_ADD, 12'd9, 8'd1, 16'd5);
      configure(13'd0, 10'd65);
      send_influence(FUNC_ADD, 12'd9, 8'd1, 16'd5);
      configure(13'd0, 10'd1023);
      send_influence(FUNC_EMIT, 12'd9, 8'd1, 16'd5);
      configure(13'd16, 10'd64);
      send_influence(FUNC_EMIT, 12'd9, 8'd1, 16'd5);
   endtask

   // Random: mostly add runs on a few vertices closed by an emit, plus noise
   task automatic test_random(int items, int idle, int stall);
      int sent;
      int vi, cnt;
      sender_idle_pct = idle;
      stall_pct = stall;
      sent = 0;
      while (sent < items) begin
         if ($urandom_range(9, 0) == 0) begin
            send_influence(1'($urandom), 12'($urandom), 8'($urandom), 16'($urandom));
            sent++;
         end else begin
            vi = (vertex_count_q > 0 && $urandom_range(7, 0) != 0)
                 ? $urandom_range(vertex_count_q - 1, 0) : $urandom_range(4095, 0);
            cnt = $urandom_range(7, 0);
            for (int k = 0; k < cnt; k++) begin
               case ($urandom_range(3, 0))
                  0: send_influence(FUNC_ADD, 12'(vi), 8'($urandom), 16'($urandom));
                  1: send_influence(FUNC_ADD, 12'(vi), 8'($urandom),
                                    16'($urandom_range(32768, 0)));
                  2: send_influence(FUNC_ADD, 12'(vi), 8'($urandom),
                                    16'($urandom_range(4, 0) * 8192));
                  default: send_influence(FUNC_ADD, 12'(vi), 8'($urandom),
                                          16'($urandom_range(3, 0)));
               endcase
            end
            send_influence(FUNC_EMIT, 12'(vi), 8'($urandom), 16'($urandom));
            sent += cnt + 1;
         end
      end
      sender_idle_pct = 0;
      stall_pct = 0;
   endtask

   // Randomize receiver stall at each falling edge
   always @(negedge clock)
      rsp_stall <= (stall_pct > 0) && ($urandom_range(99, 0) < stall_pct);

   // Compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      skin_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result status=%0d", rsp_status);
         end else begin
            e = expected_results.pop_front();
            if (rsp_status !== e.status || rsp_weight0 !== e.w[0] ||
                rsp_weight1 !== e.w[1] || rsp_weight2 !== e.w[2] ||
                rsp_weight3 !== e.w[3] || rsp_packed_bones !== e.bones) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("exp %0d %0d %0d %0d %0d %h got %0d %0d %0d %0d %0d %h",
                           e.status, e.w[0], e.w[1], e.w[2], e.w[3], e.bones,
                           rsp_status, rsp_weight0, rsp_weight1, rsp_weight2,
                           rsp_weight3, rsp_packed_bones);
            end
         end
      end
   end

   // Watchdog: count cycles without any transfer; clear sweep fits well inside
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   initial begin
      for (int v = 0; v < VERTICES_DEF; v++) begin
         tbl_n[v] = 0;
         for (int j = 0; j < 4; j++) begin
            tbl_w[v][j] = '0;
            tbl_b[v][j] = '0;
         end
      end
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(200, 0, 0);
      configure(13'd4096, 10'd1);
      test_random(180, 76, 0);
      configure(13'd300, 10'd64);
      test_random(180, 0, 76);
      configure(13'd1, 10'd0);
      test_random(40, 14, 14);
      configure(13'd2048, 10'd30);
      test_random(150, 14, 14);
      wait_drained();
      if (mismatches == 0) $display("tb: done, clean");
      else $display("tb: done, errors");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/swtn_pkg.sv
rtl/swtn_ctrl.sv
rtl/swtn_dp.sv
rtl/skin_weight_top4_normalize_core.sv
verif/tb.sv
